@@ rtl/core/rotation_matrix_to_rpy_assert.svh @@
// assertion macros used by the rpy conversion rtl
// no dependencies; included by rotation_matrix_to_rpy, which checks its own behavior
`ifndef ROTATION_MATRIX_TO_RPY_ASSERT_SVH
`define ROTATION_MATRIX_TO_RPY_ASSERT_SVH

// implication check, disabled while in reset
`define RMR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// condition that must never hold outside reset
`define RMR_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition seen");

`endif

@@ rtl/core/rmr_pkg.sv @@
// shared types, constants and the arctangent table for the rpy conversion
// no dependencies
package rmr_pkg;

  localparam int DATA_WIDTH_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ACC_W             = 64;
  localparam int ANG_W             = 32;
  localparam int ROOT_W            = 32;
  localparam int GUARD_SH          = 28;
  localparam int ATAN_ENTRIES      = 30;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef logic [ANG_W-1:0]        ang_t;
  typedef logic [ROOT_W-1:0]       root_t;
  typedef logic [ACC_W-1:0]        rem_t;

  typedef struct packed {
    logic valid;
    logic zero;
  } cell_ctl_t;

  // atan(2^-i), 2^31 = pi, rounded to nearest
  function automatic ang_t atan_entry(input int unsigned idx);
    ang_t r;
    case (idx)
      0:  r = 32'd536870912;
      1:  r = 32'd316933406;
      2:  r = 32'd167458907;
      3:  r = 32'd85004756;
      4:  r = 32'd42667331;
      5:  r = 32'd21354465;
      6:  r = 32'd10679838;
      7:  r = 32'd5340245;
      8:  r = 32'd2670163;
      9:  r = 32'd1335087;
      10: r = 32'd667544;
      11: r = 32'd333772;
      12: r = 32'd166886;
      13: r = 32'd83443;
      14: r = 32'd41722;
      15: r = 32'd20861;
      16: r = 32'd10430;
      17: r = 32'd5215;
      18: r = 32'd2608;
      19: r = 32'd1304;
      20: r = 32'd652;
      21: r = 32'd326;
      22: r = 32'd163;
      23: r = 32'd81;
      24: r = 32'd41;
      25: r = 32'd20;
      26: r = 32'd10;
      27: r = 32'd5;
      28: r = 32'd3;
      29: r = 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/rmr_sqrt_cell.sv @@
// one result bit of the pipelined integer square root
// depends on rmr_pkg
module rmr_sqrt_cell import rmr_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  rem_t  in_rem,
  input  root_t in_root,
  output logic  out_valid,
  output rem_t  out_rem,
  output root_t out_root
);

  rem_t  trial;
  rem_t  rem_next;
  root_t root_next;

  // (2*root + 2^bit) * 2^bit, root holds only bits above this one
  always_comb begin
    trial     = ({{(ACC_W-ROOT_W){1'b0}}, in_root} << (BIT + 1)) + (rem_t'(1) << (2 * BIT));
    rem_next  = in_rem;
    root_next = in_root;
    if (in_rem >= trial) begin
      rem_next  = in_rem - trial;
      root_next = in_root | (root_t'(1) << BIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_rem  <= rem_next;
    out_root <= root_next;
  end

endmodule

@@ rtl/core/rmr_cordic_cell.sv @@
// one micro-rotation of the vectoring cordic
// depends on rmr_pkg
module rmr_cordic_cell import rmr_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t in_ctl,
  input  acc_t      in_x,
  input  acc_t      in_y,
  input  ang_t      in_z,
  output cell_ctl_t out_ctl,
  output acc_t      out_x,
  output acc_t      out_y,
  output ang_t      out_z
);

  acc_t dx;
  acc_t dy;
  acc_t x_next;
  acc_t y_next;
  ang_t z_next;

  always_comb begin
    dx = in_y >>> IDX;
    dy = in_x >>> IDX;
    if (!in_y[ACC_W-1]) begin
      x_next = in_x + dx;
      y_next = in_y - dy;
      z_next = in_z + atan_entry(IDX);
    end else begin
      x_next = in_x - dx;
      y_next = in_y + dy;
      z_next = in_z - atan_entry(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= in_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_ctl.zero <= in_ctl.zero;
    out_x        <= x_next;
    out_y        <= y_next;
    out_z        <= z_next;
  end

endmodule

@@ rtl/core/rmr_cordic.sv @@
// atan2 as a row of cordic cells with a quadrant stage and a rounding stage
// depends on rmr_pkg and rmr_cordic_cell
module rmr_cordic import rmr_pkg::*; #(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  acc_t                  in_x,
  input  acc_t                  in_y,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] angle
);

  localparam int   SHIFT = ANG_W - DATA_WIDTH;
  localparam ang_t RND   = (ang_t'(1) << SHIFT) >> 1;

  cell_ctl_t ctl [CORDIC_STAGES+1];
  acc_t      xs  [CORDIC_STAGES+1];
  acc_t      ys  [CORDIC_STAGES+1];
  ang_t      zs  [CORDIC_STAGES+1];
  ang_t      z_round;

  // left half plane: turn by pi first
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ctl[0].zero <= (in_x == '0) && (in_y == '0);
    if (in_x[ACC_W-1]) begin
      xs[0] <= -in_x;
      ys[0] <= -in_y;
      zs[0] <= ang_t'(1) << (ANG_W - 1);
    end else begin
      xs[0] <= in_x;
      ys[0] <= in_y;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rmr_cordic_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_ctl  (ctl[i]),
      .in_x    (xs[i]),
      .in_y    (ys[i]),
      .in_z    (zs[i]),
      .out_ctl (ctl[i+1]),
      .out_x   (xs[i+1]),
      .out_y   (ys[i+1]),
      .out_z   (zs[i+1])
    );
  end

  assign z_round = zs[CORDIC_STAGES] + RND;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= ctl[CORDIC_STAGES].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl[CORDIC_STAGES].zero) begin
      angle <= '0;
    end else begin
      angle <= z_round[ANG_W-1 -: DATA_WIDTH];
    end
  end

endmodule

@@ rtl/core/rotation_matrix_to_rpy.sv @@
// ZYX roll, pitch and yaw from a rotation matrix
// depends on rmr_pkg, rmr_sqrt_cell, rmr_cordic and the assertion header
//
// usage: drive m00, m10, m20, m21, m22 (signed Q2.14) and raise start for
// one cycle per request. busy stays low, so a request is taken on every
// cycle that start is high, back to back at one matrix per clock.
// done pulses for one cycle with roll, pitch and yaw (signed binary angles,
// 2^(DATA_WIDTH-1) = pi) once the request has passed through the pipeline:
// two squaring/summing stages, 32 square-root cells (one root bit
// each), a quadrant stage, CORDIC_STAGES micro-rotation cells and a
// rounding stage. Results leave in request order, one per request.
// the receiver cannot stall; results must be taken when done is high.
// a synchronous rst empties the pipeline; requests in flight are dropped
// and done stays low until new requests have passed through.
module rotation_matrix_to_rpy import rmr_pkg::*; #(
  parameter int DATA_WIDTH    = DATA_WIDTH_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] m00,
  input  logic signed [DATA_WIDTH-1:0] m10,
  input  logic signed [DATA_WIDTH-1:0] m20,
  input  logic signed [DATA_WIDTH-1:0] m21,
  input  logic signed [DATA_WIDTH-1:0] m22,
  output logic                         done,
  output logic signed [DATA_WIDTH-1:0] roll,
  output logic signed [DATA_WIDTH-1:0] pitch,
  output logic signed [DATA_WIDTH-1:0] yaw
);

`include "rotation_matrix_to_rpy_assert.svh"

  localparam int SCALE_SH = ANG_W - DATA_WIDTH;
  localparam int XSH      = SCALE_SH + GUARD_SH;
  localparam int SQ_W     = 2 * DATA_WIDTH;
  localparam int PRE_LAT  = 2 + ROOT_W;
  localparam int LAT      = PRE_LAT + CORDIC_STAGES + 2;
  localparam int PACK_W   = 5 * DATA_WIDTH;

  logic signed [DATA_WIDTH:0] e21, e22;
  logic [DATA_WIDTH:0]        a21, a22;
  logic [2*DATA_WIDTH+1:0]    p21, p22;
  logic [SQ_W-1:0]            sq21, sq22;
  logic [SQ_W:0]              sq_sum;
  logic                       v_sq, v_sum;
  rem_t                       sum_scaled;

  logic  sv   [ROOT_W+1];
  rem_t  srem [ROOT_W+1];
  root_t srt  [ROOT_W+1];

  logic [PACK_W-1:0] mline [PRE_LAT];

  logic signed [DATA_WIDTH-1:0] d00, d10, d20, d21, d22;
  acc_t x_roll, y_roll, x_pitch, y_pitch, x_yaw, y_yaw;
  logic v_roll, v_pitch, v_yaw;

  assign busy = 1'b0;

  assign e21 = (DATA_WIDTH+1)'(m21);
  assign e22 = (DATA_WIDTH+1)'(m22);
  assign a21 = e21[DATA_WIDTH] ? (DATA_WIDTH+1)'(-e21) : e21;
  assign a22 = e22[DATA_WIDTH] ? (DATA_WIDTH+1)'(-e22) : e22;
  assign p21 = a21 * a21;
  assign p22 = a22 * a22;
  assign sum_scaled = rem_t'(sq_sum) << (2 * SCALE_SH);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_sq  <= 1'b0;
      v_sum <= 1'b0;
    end else begin
      v_sq  <= start;
      v_sum <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    sq21    <= p21[SQ_W-1:0];
    sq22    <= p22[SQ_W-1:0];
    sq_sum  <= (SQ_W+1)'(sq21) + (SQ_W+1)'(sq22);
    mline[0] <= {m00, m10, m20, m21, m22};
    for (int k = 1; k < PRE_LAT; k++) begin
      mline[k] <= mline[k-1];
    end
  end

  assign sv[0]   = v_sum;
  assign srem[0] = sum_scaled;
  assign srt[0]  = '0;

  // root bits from the top down
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    rmr_sqrt_cell #(.BIT(ROOT_W - 1 - j)) u_sqrt (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[j]),
      .in_rem    (srem[j]),
      .in_root   (srt[j]),
      .out_valid (sv[j+1]),
      .out_rem   (srem[j+1]),
      .out_root  (srt[j+1])
    );
  end

  assign {d00, d10, d20, d21, d22} = mline[PRE_LAT-1];

  assign x_roll  = acc_t'(d22) <<< XSH;
  assign y_roll  = acc_t'(d21) <<< XSH;
  assign x_pitch = acc_t'(srt[ROOT_W]) << GUARD_SH;
  assign y_pitch = -(acc_t'(d20) <<< XSH);
  assign x_yaw   = acc_t'(d00) <<< XSH;
  assign y_yaw   = acc_t'(d10) <<< XSH;

  rmr_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_roll (
    .clk (clk), .rst (rst), .in_valid (sv[ROOT_W]),
    .in_x (x_roll), .in_y (y_roll), .out_valid (v_roll), .angle (roll)
  );

  rmr_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_pitch (
    .clk (clk), .rst (rst), .in_valid (sv[ROOT_W]),
    .in_x (x_pitch), .in_y (y_pitch), .out_valid (v_pitch), .angle (pitch)
  );

  rmr_cordic #(.DATA_WIDTH(DATA_WIDTH), .CORDIC_STAGES(CORDIC_STAGES)) u_yaw (
    .clk (clk), .rst (rst), .in_valid (sv[ROOT_W]),
    .in_x (x_yaw), .in_y (y_yaw), .out_valid (v_yaw), .angle (yaw)
  );

  assign done = v_roll & v_pitch & v_yaw;

  `RMR_ASSERT_IMPL(a_done_follows_request, clk, rst, done, $past(start, LAT))
  `RMR_ASSERT_IMPL(a_roll_zero_vector, clk, rst, done && $past((m21 == '0) && (m22 == '0), LAT), roll == '0)
  `RMR_ASSERT_IMPL(a_yaw_zero_vector, clk, rst, done && $past((m00 == '0) && (m10 == '0), LAT), yaw == '0)
  `RMR_ASSERT_NEVER(a_no_done_after_reset, clk, rst, done && $past(rst))

endmodule

@@ verif/rotation_matrix_to_rpy_test.sv @@
// self-checking testbench for rotation_matrix_to_rpy (zyx euler angles by cordic)
// depends on rmr_pkg and the rotation_matrix_to_rpy rtl; directed table, then random matrices
module rotation_matrix_to_rpy_test import rmr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = 16;
  localparam int MW = 5 * DW;
  localparam int STAGES = 16;
  localparam int LATENCY = 36 + STAGES;
  localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;
  localparam int N_RANDOM = 600;

  typedef struct packed {
    logic signed [DW-1:0] m00, m10, m20, m21, m22;
  } matrix_t;

  typedef struct packed {
    logic signed [DW-1:0] roll, pitch, yaw;
  } angles_t;

  typedef struct {
    matrix_t m;
    logic    typed;
    angles_t a;
  } row_t;

  logic clk, rst, start, busy, done;
  logic signed [DW-1:0] m00, m10, m20, m21, m22, roll, pitch, yaw;

  rotation_matrix_to_rpy #(.DATA_WIDTH(DW), .CORDIC_STAGES(STAGES)) i_dut (
    .clk, .rst, .start, .busy, .m00, .m10, .m20, .m21, .m22,
    .done, .roll, .pitch, .yaw
  );

  angles_t pending_angles[$];
  int errors = 0;
  int n_requests = 0;
  int n_results = 0;
  int idle_count = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [DW-1:0] vector_angle(longint x, longint y);
    logic [31:0] z;
    longint dx, dy;
    z = '0;
    if (x == 0 && y == 0) return '0;
    x = x <<< GUARD_SH;
    y = y <<< GUARD_SH;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_entry(i);
      end else begin
        x -= dx; y += dy; z -= atan_entry(i);
      end
    end
    z = (z + (32'd1 << (31 - DW))) >> (32 - DW);
    return z[DW-1:0];
  endfunction

  function automatic angles_t euler_angles(matrix_t m);
    longint s00, s10, s20, s21, s22;
    logic [63:0] a21, a22, h;
    angles_t r;
    s00 = longint'(m.m00) <<< (32 - DW);
    s10 = longint'(m.m10) <<< (32 - DW);
    s20 = longint'(m.m20) <<< (32 - DW);
    s21 = longint'(m.m21) <<< (32 - DW);
    s22 = longint'(m.m22) <<< (32 - DW);
    a21 = s21 < 0 ? -s21 : s21;
    a22 = s22 < 0 ? -s22 : s22;
    h = int_sqrt(a21 * a21 + a22 * a22);
    r.roll = vector_angle(s22, s21);
    r.pitch = vector_angle(longint'(h), -s20);
    r.yaw = vector_angle(s00, s10);
    return r;
  endfunction

  function automatic matrix_t mk(int a, int b, int c, int d, int e);
    matrix_t m;
    m.m00 = DW'(a); m.m10 = DW'(b); m.m20 = DW'(c); m.m21 = DW'(d); m.m22 = DW'(e);
    return m;
  endfunction

  function automatic angles_t ang(int r, int p, int y);
    angles_t a;
    a.roll = DW'(r); a.pitch = DW'(p); a.yaw = DW'(y);
    return a;
  endfunction

  // well-formed rotation built from random angles, otherwise raw bit patterns
  function automatic matrix_t random_matrix();
    real r, p, y;
    matrix_t m;
    if ($urandom_range(0, 99) < 70) begin
      r = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.2831853;
      p = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 3.1415926;
      y = ($urandom_range(0, 65535) / 65536.0 - 0.5) * 6.2831853;
      m.m00 = DW'($rtoi(16384.0 * $cos(y) * $cos(p)));
      m.m10 = DW'($rtoi(16384.0 * $sin(y) * $cos(p)));
      m.m20 = DW'($rtoi(-16384.0 * $sin(p)));
      m.m21 = DW'($rtoi(16384.0 * $cos(p) * $sin(r)));
      m.m22 = DW'($rtoi(16384.0 * $cos(p) * $cos(r)));
    end else begin
      m = MW'({$urandom, $urandom, $urandom});
    end
    return m;
  endfunction

  task automatic issue(matrix_t m, logic typed, angles_t a);
    while ($urandom_range(0, 99) < 16 && n_requests > 200) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    {m00, m10, m20, m21, m22} <= m;
    pending_angles.push_back(typed ? a : euler_angles(m));
    @(posedge clk);
    while (busy) @(posedge clk);
    n_requests++;
  endtask

  always @(posedge clk) begin
    angles_t want;
    if (!rst && done) begin
      n_results++;
      if (pending_angles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d %0d %0d", roll, pitch, yaw);
      end else begin
        want = pending_angles.pop_front();
        if (roll !== want.roll || pitch !== want.pitch || yaw !== want.yaw) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                     want.roll, want.pitch, want.yaw, roll, pitch, yaw);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    rst = 1'b1;
    start = 1'b0;
    {m00, m10, m20, m21, m22} = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // all-zero vectors give angle zero; x negative with y zero wraps to pi code
    rows.push_back('{mk(0, 0, 0, 0, 0), 1'b1, ang(0, 0, 0)});
    rows.push_back('{mk(-16384, 0, 0, 0, -16384), 1'b1, ang(-32768, 0, -32768)});
    rows.push_back('{mk(16384, 0, 0, 0, 16384), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(0, 16384, 16384, 16384, 0), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(0, -16384, -16384, -16384, 0), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(32767, 32767, 32767, 32767, 32767), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(-32768, -32768, -32768, -32768, -32768), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(-32768, 32767, -32768, 32767, -32768), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(32767, -32768, 32767, -32768, 32767), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(-1, 0, 1, -1, -1), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(1, -1, -1, 1, 1), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(11585, 11585, -11585, 8192, 8192), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(-11585, -11585, 11585, -8192, 8192), 1'b0, ang(0, 0, 0)});
    rows.push_back('{mk(0, 0, 32767, 0, 0), 1'b0, ang(0, 0, 0)});
    foreach (rows[i]) issue(rows[i].m, rows[i].typed, rows[i].a);
    for (int i = 0; i < N_RANDOM; i++) issue(random_matrix(), 1'b0, ang(0, 0, 0));
    start <= 1'b0;

    while (pending_angles.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("%0d matrices sent (directed extremes and zero vectors, rotations, raw patterns)",
             n_requests);
    $display("%0d angle triples checked, %0d errors", n_results, errors);
    if (errors == 0 && pending_angles.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
